@@ hw/rtl/kts_pkg.sv @@
`default_nettype none

package kts_pkg;

	localparam int unsigned DEPTH = 64;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// Contents of one sorting cell.
	typedef struct packed {
		logic               valid;
		logic signed [31:0] key;
		logic [31:0]        tag;
	} entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic               load;
		logic               unload;
		logic signed [31:0] key;
		logic [31:0]        tag;
	} cell_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/keyed_tag_sorter.sv @@
// Channel  | Handshake               | Fields
// ---------+-------------------------+--------------------------------------------
// input    | start, busy             | key, tag, last_in
// result   | result_strobe           | sorted_key, sorted_tag, last_out, overflow
//
// While loading, an item is taken whenever start is high; the cell chain inserts it in place unless full.
// After the item marked last_in, the chain shifts one result out per cycle until every
// stored item is out; busy is high while it drains.
// The receiver cannot stall: each result is shown for one cycle only.
// Reset empties the chain and clears the count and the drop flag.
`default_nettype none

module keyed_tag_sorter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] key,
	input  wire logic [31:0]        tag,
	input  wire logic               last_in,
	output logic                    result_strobe,
	output logic signed [31:0]      sorted_key,
	output logic [31:0]             sorted_tag,
	output logic                    last_out,
	output logic                    overflow
);
	import kts_pkg::*;

	typedef enum logic {
		ST_LOAD,
		ST_UNLOAD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] remain_q;
	logic             dropped_q;
	logic             run_ovf_q;

	cell_cmd_t        cmd;
	entry_t           cells [DEPTH];
	logic             ins [DEPTH];

	logic             accept;
	logic             full;

	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(DEPTH));

	always_comb begin
		cmd.load   = accept && !full;
		cmd.unload = (state_q == ST_UNLOAD);
		cmd.key    = key;
		cmd.tag    = tag;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t l_entry;
		entry_t r_entry;
		logic   l_ins;

		if (i == 0) begin : g_head
			assign l_entry = '0;
			assign l_ins   = 1'b0;
		end else begin : g_body
			assign l_entry = cells[i-1];
			assign l_ins   = ins[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_entry = '0;
		end else begin : g_next
			assign r_entry = cells[i+1];
		end

		kts_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.ins_left (l_ins),
			.left     (l_entry),
			.right    (r_entry),
			.entry    (cells[i]),
			.ins      (ins[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			busy          <= 1'b0;
			count_q       <= '0;
			remain_q      <= '0;
			dropped_q     <= 1'b0;
			run_ovf_q     <= 1'b0;
			result_strobe <= 1'b0;
			sorted_key    <= '0;
			sorted_tag    <= '0;
			last_out      <= 1'b0;
			overflow      <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (last_in) begin
							state_q   <= ST_UNLOAD;
							busy      <= 1'b1;
							remain_q  <= full ? count_q : count_q + CNT_W'(1);
							run_ovf_q <= dropped_q || full;
							count_q   <= '0;
							dropped_q <= 1'b0;
						end else if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_UNLOAD: begin
					result_strobe <= 1'b1;
					sorted_key    <= cells[0].key;
					sorted_tag    <= cells[0].tag;
					last_out      <= (remain_q == CNT_W'(1));
					overflow      <= run_ovf_q;
					remain_q      <= remain_q - CNT_W'(1);
					if (remain_q == CNT_W'(1)) begin
						state_q <= ST_LOAD;
						busy    <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
					busy    <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/kts_cell.sv @@
`default_nettype none

module kts_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kts_pkg::cell_cmd_t cmd,
	input  wire logic              ins_left,
	input  wire kts_pkg::entry_t   left,
	input  wire kts_pkg::entry_t   right,
	output kts_pkg::entry_t        entry,
	output logic                   ins
);
	import kts_pkg::*;

	logic               valid_q;
	logic signed [31:0] key_q;
	logic [31:0]        tag_q;

	// The new item goes into an empty cell, or in front of this cell's item only on a strict less,
	// which keeps equal keys in arrival order.
	assign ins = !valid_q || ($signed(cmd.key) < $signed(key_q));

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.tag   = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.unload) begin
			valid_q <= right.valid;
		end else if (cmd.load) begin
			if (ins_left) begin
				valid_q <= left.valid;
			end else if (ins) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.unload) begin
			key_q <= right.key;
			tag_q <= right.tag;
		end else if (cmd.load) begin
			if (ins_left) begin
				key_q <= left.key;
				tag_q <= left.tag;
			end else if (ins) begin
				key_q <= cmd.key;
				tag_q <= cmd.tag;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/kts_checker.sv @@
`default_nettype none

module kts_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic last_in,
	input wire logic result_strobe,
	input wire logic last_out
);

	// Accepting the final item of a set starts draining.
	a_last_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_in |=> busy)
		else $error("final item did not start the drain");

	// Every draining cycle yields one result in the next cycle.
	a_drain_emits: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> result_strobe)
		else $error("drain cycle produced no result");

	// The final result of a run releases the block.
	a_last_releases: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last_out |-> !busy)
		else $error("block still busy after final result");

	// A result that is not the final one leaves the block draining.
	a_mid_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last_out |-> busy)
		else $error("run ended without a final result");

	// Results appear only after a draining cycle.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result without a draining cycle");

endmodule

bind keyed_tag_sorter kts_checker u_kts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.last_in       (last_in),
	.result_strobe (result_strobe),
	.last_out      (last_out)
);

`default_nettype wire
